[src/jsu_pkg.sv]
// shared types and constants of the json string unescaper
`default_nettype none
package jsu_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_QUOTE  = 3'd1,
    ERR_CTRL      = 3'd2,
    ERR_BAD_ESC   = 3'd3,
    ERR_BAD_HEX   = 3'd4,
    ERR_BAD_SURR  = 3'd5
  } err_code_t;

  // request operation passed from front to back
  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_CP    = 2'd1,
    OP_CLOSE = 2'd2,
    OP_ERR   = 2'd3
  } req_op_t;

  typedef struct packed {
    req_op_t     op;
    err_code_t   err;
    logic [20:0] cp;
  } jsu_req_t;

  typedef struct packed {
    logic     push;
    jsu_req_t req;
  } jsu_push_t;

  typedef struct packed {
    logic     not_empty;
    logic     full;
    jsu_req_t head;
  } jsu_qstat_t;

endpackage
`default_nettype wire

[src/jsu_front.sv]
// front end: escape and surrogate parser that turns bytes into requests
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire logic [7:0] in_byte,
  output jsu_push_t      push
);

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_ESC  = 4'd1,
    M_HEX1 = 4'd2,
    M_BSL  = 4'd3,
    M_LOWU = 4'd4,
    M_HEX2 = 4'd5
  } mode_t;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5c;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6e;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChU     = 8'h75;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  high_r, high_nxt;

  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  logic [4:0]  hv;
  logic [15:0] acc_sh;
  logic [20:0] supp_cp;

  assign hv      = hexval(in_byte);
  assign acc_sh  = {acc_r[11:0], hv[3:0]};
  assign supp_cp = 21'({high_r, acc_sh[9:0]}) + 21'h10000;

  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    high_nxt      = high_r;
    push.push     = 1'b0;
    push.req.op   = OP_RAW;
    push.req.err  = ERR_NONE;
    push.req.cp   = 21'(in_byte);
    if (accept) begin
      case (mode_r)
        M_ESC: begin
          mode_nxt = M_IDLE;
          push.push = 1'b1;
          case (in_byte)
            ChQuote, ChBsl, ChSlash: push.req.cp = 21'(in_byte);
            ChB: push.req.cp = 21'h08;
            ChF: push.req.cp = 21'h0c;
            ChN: push.req.cp = 21'h0a;
            ChT: push.req.cp = 21'h09;
            ChR: push.req.cp = 21'h0d;
            ChU: begin
              push.push = 1'b0;
              mode_nxt  = M_HEX1;
              acc_nxt   = 16'd0;
              cnt_nxt   = 2'd0;
            end
            default: begin
              push.req.op  = OP_ERR;
              push.req.err = ERR_BAD_ESC;
              push.req.cp  = 21'd0;
              acc_nxt      = 16'd0;
              cnt_nxt      = 2'd0;
              high_nxt     = 10'd0;
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (hv[4]) begin
            push.push    = 1'b1;
            push.req.op  = OP_ERR;
            push.req.err = ERR_BAD_HEX;
            push.req.cp  = 21'd0;
            mode_nxt     = M_IDLE;
            acc_nxt      = 16'd0;
            cnt_nxt      = 2'd0;
            high_nxt     = 10'd0;
          end else begin
            acc_nxt = acc_sh;
            if (cnt_r != 2'd3) begin
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              cnt_nxt = 2'd0;
              acc_nxt = 16'd0;
              if (mode_r == M_HEX1) begin
                if (acc_sh[15:10] == 6'b110110) begin
                  high_nxt = acc_sh[9:0];
                  mode_nxt = M_BSL;
                end else begin
                  push.push   = 1'b1;
                  push.req.op = OP_CP;
                  push.req.cp = 21'(acc_sh);
                  mode_nxt    = M_IDLE;
                end
              end else begin
                push.push = 1'b1;
                mode_nxt  = M_IDLE;
                high_nxt  = 10'd0;
                if (acc_sh[15:10] != 6'b110111) begin
                  push.req.op  = OP_ERR;
                  push.req.err = ERR_BAD_SURR;
                  push.req.cp  = 21'd0;
                end else begin
                  push.req.op = OP_CP;
                  push.req.cp = supp_cp;
                end
              end
            end
          end
        end
        M_BSL, M_LOWU: begin
          if ((mode_r == M_BSL && in_byte != ChBsl) ||
              (mode_r == M_LOWU && in_byte != ChU)) begin
            push.push    = 1'b1;
            push.req.op  = OP_ERR;
            push.req.err = ERR_BAD_SURR;
            push.req.cp  = 21'd0;
            mode_nxt     = M_IDLE;
            acc_nxt      = 16'd0;
            cnt_nxt      = 2'd0;
            high_nxt     = 10'd0;
          end else if (mode_r == M_BSL) begin
            mode_nxt = M_LOWU;
          end else begin
            mode_nxt = M_HEX2;
            acc_nxt  = 16'd0;
            cnt_nxt  = 2'd0;
          end
        end
        default: begin
          mode_nxt  = M_IDLE;
          push.push = 1'b1;
          if (in_byte == ChQuote) begin
            push.req.op = OP_CLOSE;
            push.req.cp = 21'd0;
          end else if (in_byte < 8'h20) begin
            push.req.op  = OP_ERR;
            push.req.err = (in_byte == 8'h00) ? ERR_NO_QUOTE : ERR_CTRL;
            push.req.cp  = 21'd0;
            acc_nxt      = 16'd0;
            cnt_nxt      = 2'd0;
            high_nxt     = 10'd0;
          end else if (in_byte == ChBsl) begin
            push.push = 1'b0;
            mode_nxt  = M_ESC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= 16'd0;
      cnt_r  <= 2'd0;
      high_r <= 10'd0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      high_r <= high_nxt;
    end
  end

endmodule
`default_nettype wire

[src/jsu_queue.sv]
// request queue between front and back
`default_nettype none
module jsu_queue
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire jsu_push_t  push,
  input  wire logic       pop,
  output jsu_qstat_t      stat
);

  jsu_req_t         mem_r [QDepth];
  logic [QAw-1:0]   wr_r, wr_nxt;
  logic [QAw-1:0]   rd_r, rd_nxt;
  logic [QAw:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push.push && (cnt_r != (QAw+1)'(QDepth));
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_nxt  = do_push ? wr_r + QAw'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QAw'(1) : rd_r;
    cnt_nxt = cnt_r + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
  end

  assign stat.not_empty = (cnt_r != '0);
  assign stat.full      = (cnt_r == (QAw+1)'(QDepth));
  assign stat.head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[src/jsu_back.sv]
// back end: utf-8 encoder and output register
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire jsu_qstat_t  stat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_error_code,
  output logic             out_last
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  out_kind_t  kind_r, kind_nxt;
  err_code_t  err_r;
  logic       last_r, last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] nlast;
  logic       load;
  jsu_req_t   h;

  assign h    = stat.head;
  assign load = stat.not_empty && (!valid_r || !out_stall);

  always_comb begin
    nlast    = 2'd0;
    kind_nxt = KIND_BYTE;
    byte_nxt = 8'd0;
    case (h.op)
      OP_CP: begin
        if (h.cp <= 21'h7f) nlast = 2'd0;
        else if (h.cp <= 21'h7ff) nlast = 2'd1;
        else if (h.cp <= 21'hffff) nlast = 2'd2;
        else nlast = 2'd3;
        case (nlast)
          2'd0: byte_nxt = h.cp[7:0];
          2'd1: byte_nxt = (idx_r == 2'd0) ? {3'b110, h.cp[10:6]} : {2'b10, h.cp[5:0]};
          2'd2: begin
            case (idx_r)
              2'd0:    byte_nxt = {4'b1110, h.cp[15:12]};
              2'd1:    byte_nxt = {2'b10, h.cp[11:6]};
              default: byte_nxt = {2'b10, h.cp[5:0]};
            endcase
          end
          default: begin
            case (idx_r)
              2'd0:    byte_nxt = {5'b11110, h.cp[20:18]};
              2'd1:    byte_nxt = {2'b10, h.cp[17:12]};
              2'd2:    byte_nxt = {2'b10, h.cp[11:6]};
              default: byte_nxt = {2'b10, h.cp[5:0]};
            endcase
          end
        endcase
      end
      OP_CLOSE: kind_nxt = KIND_CLOSE;
      OP_ERR:   kind_nxt = KIND_ERROR;
      default:  byte_nxt = h.cp[7:0];
    endcase
    last_nxt = (idx_r == nlast);
    pop      = load && last_nxt;
    idx_nxt  = idx_r;
    if (load) begin
      idx_nxt = last_nxt ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      err_r  <= h.err;
      last_r <= last_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

[src/json_string_unescape.sv]
// top level of the json string unescaper
// Accepts one byte of a JSON string body per cycle while not stalled, starting after the
// opening quote, and returns decoded bytes, a close marker on the closing quote, or an
// error marker, each with a last flag on the final result caused by an input byte. The
// front parser takes a byte every cycle while the four-entry request queue has room; the
// back end sends one result per cycle while out_stall is low, so a code point that encodes
// to 2, 3 or 4 UTF-8 bytes holds the queue head until its last byte is out. A result passes
// through the queue and the output register. in_stall is high while the queue is full.
`default_nettype none
module json_string_unescape
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic [2:0]      out_error_code,
  output logic            out_last
);

  jsu_push_t  push;
  jsu_qstat_t stat;
  logic       pop;
  logic       accept;

  assign in_stall = stat.full;
  assign accept   = in_valid && !stat.full;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
